FILE: src/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the fixed block pool allocator.
// Used by fbpa_div, fbpa_dp, fbpa_ctrl and fixed_block_pool_allocator.
// Depends on nothing.
package fbpa_pkg;

	localparam int ADDR_W    = 32;
	localparam int BB_W      = 16;
	localparam int STRIDE_W  = 17;
	localparam int ACT_W     = 2;
	localparam int ST_W      = 2;
	localparam int FC_W      = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INIT    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [ST_W-1:0] ST_SIZE    = 2'd2;
	localparam logic [ST_W-1:0] ST_BADADDR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_CHK,
		S_ALLOC_POP,
		S_REL_CHK,
		S_REL_DIV,
		S_REL_END,
		S_INIT_DIV,
		S_INIT_WAIT,
		S_INIT_SET,
		S_INIT_LINK,
		S_INIT_DONE,
		S_BAD
	} fbpa_state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_CAPTURE,
		DP_MUL,
		DP_NOMEM,
		DP_POP,
		DP_REL_DIV,
		DP_BAD,
		DP_PUSH,
		DP_INIT_DIV,
		DP_INIT_EMPTY,
		DP_INIT_SET,
		DP_LINK,
		DP_INIT_OK
	} fbpa_op_t;

	typedef struct packed {
		fbpa_op_t op;
	} fbpa_cmd_t;

	typedef struct packed {
		logic alloc_ok;
		logic rel_pre_bad;
		logic rel_bad;
		logic div_done;
		logic quo_zero;
		logic link_last;
	} fbpa_stat_t;

endpackage

FILE: src/fbpa_div.sv
// fbpa_div: restoring divider, one quotient bit per cycle.
// 32-bit dividend by 17-bit nonzero divisor. Depends on fbpa_pkg.
module fbpa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [fbpa_pkg::ADDR_W-1:0]    dividend,
	input  logic [fbpa_pkg::STRIDE_W-1:0]  divisor,
	output logic [fbpa_pkg::ADDR_W-1:0]    quotient,
	output logic [fbpa_pkg::STRIDE_W-1:0]  remainder,
	output logic                           done
);
	import fbpa_pkg::*;

	localparam int STEP_W = $clog2(ADDR_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

	logic                  run_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [ADDR_W-1:0]     quo_q;
	logic [STRIDE_W-1:0]   rem_q;
	logic [STRIDE_W-1:0]   dvs_q;
	logic [STRIDE_W:0]     trial;
	logic [STRIDE_W:0]     trial_sub;
	logic                  fits;

	assign trial     = {rem_q, quo_q[ADDR_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], fits};
			rem_q <= fits ? trial_sub[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

FILE: src/fbpa_dp.sv
// fbpa_dp: allocator datapath: config registers, free-list link memory,
// head/count registers, address multiply and the shared divider.
// Depends on fbpa_pkg and fbpa_div.
module fbpa_dp #(
	parameter int MAX_BLOCKS = 256,
	parameter int LINK_BYTES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_data,
	input  logic [fbpa_pkg::ADDR_W-1:0]     release_address,
	input  fbpa_pkg::fbpa_cmd_t             cmd,
	output fbpa_pkg::fbpa_stat_t            stat,
	output logic [fbpa_pkg::ST_W-1:0]       status,
	output logic [fbpa_pkg::ADDR_W-1:0]     block_address,
	output logic [fbpa_pkg::FC_W-1:0]       free_count
);
	import fbpa_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PROD_W = CNT_W + STRIDE_W;
	localparam logic [CNT_W-1:0]    NULL_IDX = CNT_W'(MAX_BLOCKS);
	localparam logic [ADDR_W-1:0]   LINK_OFF = ADDR_W'(LINK_BYTES);
	localparam logic [STRIDE_W-1:0] LINK_STR = STRIDE_W'(LINK_BYTES);
	localparam logic [ADDR_W-1:0]   MAX_W32  = ADDR_W'(MAX_BLOCKS);

	logic [ADDR_W-1:0]   base_q;
	logic [BB_W-1:0]     bbytes_q;
	logic [ADDR_W-1:0]   pbytes_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [CNT_W-1:0]    head_q;
	logic [CNT_W-1:0]    avail_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT_W-1:0]    rd_q;
	logic [ST_W-1:0]     status_q;
	logic [ADDR_W-1:0]   baddr_q;

	logic [CNT_W-1:0]    link_mem [MAX_BLOCKS];

	logic [ADDR_W-1:0]   off;
	logic [STRIDE_W-1:0] bs_round;
	logic [STRIDE_W-1:0] stride_n;
	logic                div_go;
	logic [ADDR_W-1:0]   div_dividend;
	logic [STRIDE_W-1:0] div_divisor;
	logic [ADDR_W-1:0]   quo;
	logic [STRIDE_W-1:0] rem;
	logic                div_done;
	logic [CNT_W-1:0]    cap_n;
	logic [CNT_W-1:0]    cnt_inc;
	logic                link_last;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [CNT_W-1:0]    mem_wdata;
	logic [ADDR_W-1:0]   avail32;

	assign off      = addr_q - base_q;
	assign bs_round = (STRIDE_W'(bbytes_q) + STRIDE_W'(3)) & ~STRIDE_W'(3);
	assign stride_n = bs_round + LINK_STR;

	assign div_go       = (cmd.op == DP_INIT_DIV) || (cmd.op == DP_REL_DIV);
	assign div_dividend = (cmd.op == DP_INIT_DIV) ? (pbytes_q & ~ADDR_W'(3)) : (off - LINK_OFF);
	assign div_divisor  = (cmd.op == DP_INIT_DIV) ? stride_n : stride_q;

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (quo),
		.remainder (rem),
		.done      (div_done)
	);

	assign cap_n     = (quo > MAX_W32) ? NULL_IDX : quo[CNT_W-1:0];
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign link_last = (cnt_inc == total_q);

	always_comb begin
		stat.alloc_ok    = (avail_q != '0) && (head_q < total_q);
		stat.rel_pre_bad = (total_q == '0) || (avail_q >= total_q) || (off < LINK_OFF);
		stat.rel_bad     = (rem != '0) || (quo >= ADDR_W'(total_q));
		stat.div_done    = div_done;
		stat.quo_zero    = (quo == '0);
		stat.link_last   = link_last;
	end

	// one write port: init link sweep or release push
	assign mem_we    = (cmd.op == DP_LINK) || (cmd.op == DP_PUSH);
	assign mem_waddr = (cmd.op == DP_LINK) ? cnt_q[AW-1:0] : quo[AW-1:0];
	assign mem_wdata = (cmd.op == DP_LINK) ? (link_last ? NULL_IDX : cnt_inc) : head_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[mem_waddr] <= mem_wdata;
		rd_q <= link_mem[head_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bbytes_q <= '0;
			pbytes_q <= '0;
			stride_q <= '0;
			head_q   <= NULL_IDX;
			avail_q  <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POOL_BASE:   base_q   <= cfg_data;
					CFG_BLOCK_BYTES: bbytes_q <= cfg_data[BB_W-1:0];
					CFG_POOL_BYTES:  pbytes_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (cmd.op)
				DP_POP: begin
					head_q  <= rd_q;
					avail_q <= avail_q - CNT_W'(1);
				end
				DP_PUSH: begin
					head_q  <= quo[CNT_W-1:0];
					avail_q <= avail_q + CNT_W'(1);
				end
				DP_INIT_DIV: stride_q <= stride_n;
				DP_INIT_EMPTY: begin
					total_q <= '0;
					avail_q <= '0;
					head_q  <= NULL_IDX;
				end
				DP_INIT_SET: begin
					total_q <= cap_n;
					avail_q <= cap_n;
				end
				DP_INIT_OK: head_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_CAPTURE: addr_q <= release_address;
			DP_MUL:     prod_q <= PROD_W'(head_q) * PROD_W'(stride_q);
			DP_INIT_SET: cnt_q <= '0;
			DP_LINK:    cnt_q  <= cnt_inc;
			DP_NOMEM: begin
				status_q <= ST_NOMEM;
				baddr_q  <= '0;
			end
			DP_POP: begin
				status_q <= ST_OK;
				baddr_q  <= base_q + ADDR_W'(prod_q) + LINK_OFF;
			end
			DP_BAD: begin
				status_q <= ST_BADADDR;
				baddr_q  <= '0;
			end
			DP_PUSH, DP_INIT_OK: begin
				status_q <= ST_OK;
				baddr_q  <= '0;
			end
			DP_INIT_EMPTY: begin
				status_q <= ST_SIZE;
				baddr_q  <= '0;
			end
			default: ;
		endcase
	end

	assign avail32       = ADDR_W'(avail_q);
	assign free_count    = avail32[FC_W-1:0];
	assign status        = status_q;
	assign block_address = baddr_q;

	a_avail_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= total_q)
		else $error("free count above block count");

	a_total_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= NULL_IDX)
		else $error("block count above pool limit");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_PUSH |=> avail_q == $past(avail_q) + CNT_W'(1))
		else $error("release did not bump free count");

endmodule

FILE: src/fbpa_ctrl.sv
// fbpa_ctrl: sequencer for allocate, release and initialize.
// Drives datapath ops, the busy flag and the done strobe. Depends on fbpa_pkg.
module fbpa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbpa_pkg::ACT_W-1:0]  action,
	input  fbpa_pkg::fbpa_stat_t        stat,
	output fbpa_pkg::fbpa_cmd_t         cmd,
	output logic                        busy,
	output logic                        done
);
	import fbpa_pkg::*;

	fbpa_state_t state_q;
	fbpa_state_t state_n;
	logic        done_q;
	logic        accept;
	logic        finish;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_ALLOC:   state_n = S_ALLOC_CHK;
						ACT_RELEASE: state_n = S_REL_CHK;
						ACT_INIT:    state_n = S_INIT_DIV;
						default:     state_n = S_BAD;
					endcase
				end
			end
			S_ALLOC_CHK: state_n = stat.alloc_ok ? S_ALLOC_POP : S_IDLE;
			S_ALLOC_POP: state_n = S_IDLE;
			S_REL_CHK:   state_n = stat.rel_pre_bad ? S_IDLE : S_REL_DIV;
			S_REL_DIV:   state_n = stat.div_done ? S_REL_END : S_REL_DIV;
			S_REL_END:   state_n = S_IDLE;
			S_INIT_DIV:  state_n = S_INIT_WAIT;
			S_INIT_WAIT: state_n = stat.div_done ? S_INIT_SET : S_INIT_WAIT;
			S_INIT_SET:  state_n = stat.quo_zero ? S_IDLE : S_INIT_LINK;
			S_INIT_LINK: state_n = stat.link_last ? S_INIT_DONE : S_INIT_LINK;
			S_INIT_DONE: state_n = S_IDLE;
			S_BAD:       state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = DP_NONE;
		unique case (state_q)
			S_IDLE:      cmd.op = accept ? DP_CAPTURE : DP_NONE;
			S_ALLOC_CHK: cmd.op = stat.alloc_ok ? DP_MUL : DP_NOMEM;
			S_ALLOC_POP: cmd.op = DP_POP;
			S_REL_CHK:   cmd.op = stat.rel_pre_bad ? DP_BAD : DP_REL_DIV;
			S_REL_DIV:   cmd.op = DP_NONE;
			S_REL_END:   cmd.op = stat.rel_bad ? DP_BAD : DP_PUSH;
			S_INIT_DIV:  cmd.op = DP_INIT_DIV;
			S_INIT_WAIT: cmd.op = DP_NONE;
			S_INIT_SET:  cmd.op = stat.quo_zero ? DP_INIT_EMPTY : DP_INIT_SET;
			S_INIT_LINK: cmd.op = DP_LINK;
			S_INIT_DONE: cmd.op = DP_INIT_OK;
			S_BAD:       cmd.op = DP_BAD;
			default:     cmd.op = DP_NONE;
		endcase
	end

	// ops that load the result word
	assign finish = cmd.op inside {DP_NOMEM, DP_POP, DP_BAD, DP_PUSH, DP_INIT_EMPTY,
		DP_INIT_OK};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still working");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

endmodule

FILE: src/fixed_block_pool_allocator.sv
// Fixed block pool allocator: start/busy command port, one result word per
// command strobed by done for a single cycle; the receiver cannot stall, so
// results must be taken in the done cycle. Allocate checks the head and
// multiplies index by stride while the link memory is read, then pops; an
// empty pool ends after the check with a no-memory status. Release and
// initialize both wait on the bit-serial 32-step divider; initialize then
// writes one link word per cycle into the free-list memory. A release that
// fails the range checks before the divide, and the unused action code, end
// with a bad-address status. A new command may be accepted in the done cycle.
// Config writes must go in only while idle; the block itself does not enforce this.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256,
	parameter int LINK_BYTES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [fbpa_pkg::ACT_W-1:0]      action,
	input  logic [fbpa_pkg::ADDR_W-1:0]     release_address,
	output logic                            done,
	output logic [fbpa_pkg::ST_W-1:0]       status,
	output logic [fbpa_pkg::ADDR_W-1:0]     block_address,
	output logic [fbpa_pkg::FC_W-1:0]       free_count
);
	import fbpa_pkg::*;

	fbpa_cmd_t  cmd;
	fbpa_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.LINK_BYTES (LINK_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.release_address (release_address),
		.cmd             (cmd),
		.stat            (stat),
		.status          (status),
		.block_address   (block_address),
		.free_count      (free_count)
	);

endmodule
